// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both macros expect a signal named clk, and
// PSG_ASSERT also expects rst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while the block is out of reset.
`define PSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, including the ones during reset.
`define PSG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PSG_ASSERT(label, prop, msg)
`define PSG_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/psg_pkg.sv =====
`default_nettype none

package psg_pkg;

  localparam int NUM_TONES  = 3;
  localparam int NUM_CHANS  = 4;
  localparam int PERIOD_W   = 10;
  localparam int ATTEN_W    = 4;
  localparam int AMP_W      = 13;
  localparam int LEVEL_W    = 15;
  localparam int LFSR_W     = 16;

  // Item kinds on the input channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Channel number of the noise generator in latch bytes.
  localparam logic [1:0] NOISE_CH = 2'd3;

  // Noise rate select, bits 1-0 of the noise control register.
  localparam logic [1:0] NOISE_RATE_16 = 2'd0;
  localparam logic [1:0] NOISE_RATE_32 = 2'd1;
  localparam logic [1:0] NOISE_RATE_64 = 2'd2;
  localparam logic [1:0] NOISE_RATE_T2 = 2'd3;

  localparam logic [PERIOD_W-1:0] NOISE_PER_16 = 10'h010;
  localparam logic [PERIOD_W-1:0] NOISE_PER_32 = 10'h020;
  localparam logic [PERIOD_W-1:0] NOISE_PER_64 = 10'h040;

  localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'h8000;
  localparam logic [ATTEN_W-1:0] ATTEN_MUTE  = 4'hF;
  localparam logic [7:0]         MASK_RESET  = 8'hFF;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic [3:0]         channel_bits;
  } out_item_t;

  // Amplitude for each attenuation step, loudest first.
  function automatic logic [AMP_W-1:0] vol_amp(input logic [ATTEN_W-1:0] att);
    logic [AMP_W-1:0] amp;
    case (att)
      4'd0:    amp = 13'd8000;
      4'd1:    amp = 13'd6355;
      4'd2:    amp = 13'd5048;
      4'd3:    amp = 13'd4010;
      4'd4:    amp = 13'd3186;
      4'd5:    amp = 13'd2531;
      4'd6:    amp = 13'd2010;
      4'd7:    amp = 13'd1597;
      4'd8:    amp = 13'd1268;
      4'd9:    amp = 13'd1008;
      4'd10:   amp = 13'd800;
      4'd11:   amp = 13'd636;
      4'd12:   amp = 13'd505;
      4'd13:   amp = 13'd401;
      4'd14:   amp = 13'd319;
      default: amp = 13'd0;
    endcase
    return amp;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psg_tone_noise_generator.sv =====
`default_nettype none
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    psg_pkg::in_item_t (action, data_byte)
// out_     output     out_valid / out_stall  psg_pkg::out_item_t (left, right, bits)
// cfg_     input      cfg_valid / cfg_ready  cfg_data, stereo mask
//
// One request per clock is taken while the result is not stalled; each passes an input
// register, then state update plus level summing into the result register.
// Synchronous active-low reset silences all channels and restores the stereo mask.
// A stalled result holds the result register and then the input register; the
// generator state only advances when a request moves into the result register.

module psg_tone_noise_generator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire psg_pkg::in_item_t   in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      psg_pkg::out_item_t  out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [7:0]          cfg_data
);
  import psg_pkg::*;

  `include "assert_macros.svh"

  // Input register.
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Result register.
  logic      out_valid_r;
  out_item_t out_item_r;

  // Generator state.
  logic [7:0]          mask_r;
  logic [1:0]          lat_ch_r, lat_ch_nxt;
  logic                lat_vol_r, lat_vol_nxt;
  logic [PERIOD_W-1:0] tone_per_r [NUM_TONES];
  logic [PERIOD_W-1:0] tone_per_nxt [NUM_TONES];
  logic [3:0]          noise_ctl_r, noise_ctl_nxt;
  logic [ATTEN_W-1:0]  atten_r [NUM_CHANS];
  logic [ATTEN_W-1:0]  atten_nxt [NUM_CHANS];
  logic [PERIOD_W-1:0] cnt_r [NUM_CHANS];
  logic [PERIOD_W-1:0] cnt_nxt [NUM_CHANS];
  logic [NUM_TONES-1:0] tone_out_r, tone_out_nxt;
  logic                noise_tog_r, noise_tog_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;

  logic                out_free;
  logic                adv;
  logic                noise_wr;
  logic [1:0]          eff_ch;
  logic                eff_vol;
  logic                is_latch;
  logic [PERIOD_W-1:0] noise_per;
  logic                fb;
  logic [NUM_CHANS-1:0] chan_bits;
  logic [AMP_W-1:0]    amp [NUM_CHANS];
  logic [LEVEL_W-1:0]  left_sum, right_sum;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Next generator state for the request in the input register.
  always_comb begin
    lat_ch_nxt    = lat_ch_r;
    lat_vol_nxt   = lat_vol_r;
    tone_per_nxt  = tone_per_r;
    noise_ctl_nxt = noise_ctl_r;
    atten_nxt     = atten_r;
    cnt_nxt       = cnt_r;
    tone_out_nxt  = tone_out_r;
    noise_tog_nxt = noise_tog_r;
    lfsr_nxt      = lfsr_r;
    noise_wr      = 1'b0;
    noise_per     = NOISE_PER_16;
    fb            = 1'b0;

    is_latch = s1_item_r.data_byte[7];
    eff_ch   = is_latch ? s1_item_r.data_byte[6:5] : lat_ch_r;
    eff_vol  = is_latch ? s1_item_r.data_byte[4] : lat_vol_r;

    if (s1_item_r.action == ACT_WRITE) begin
      lat_ch_nxt  = eff_ch;
      lat_vol_nxt = eff_vol;
      if (eff_vol) begin
        atten_nxt[eff_ch] = s1_item_r.data_byte[3:0];
      end else if (eff_ch == NOISE_CH) begin
        noise_ctl_nxt = s1_item_r.data_byte[3:0];
        lfsr_nxt      = LFSR_SEED;
        noise_wr      = 1'b1;
      end else begin
        for (int i = 0; i < NUM_TONES; i++) begin
          if (eff_ch == 2'(i)) begin
            if (is_latch) begin
              tone_per_nxt[i][3:0] = s1_item_r.data_byte[3:0];
            end else begin
              tone_per_nxt[i][9:4] = s1_item_r.data_byte[5:0];
            end
          end
        end
      end
    end else begin
      // A period of zero or one parks the tone high with its counter frozen.
      for (int i = 0; i < NUM_TONES; i++) begin
        if (tone_per_r[i] <= PERIOD_W'(1)) begin
          tone_out_nxt[i] = 1'b1;
        end else if (cnt_r[i] <= PERIOD_W'(1)) begin
          cnt_nxt[i]      = tone_per_r[i];
          tone_out_nxt[i] = ~tone_out_r[i];
        end else begin
          cnt_nxt[i] = cnt_r[i] - PERIOD_W'(1);
        end
      end

      case (noise_ctl_r[1:0])
        NOISE_RATE_16: noise_per = NOISE_PER_16;
        NOISE_RATE_32: noise_per = NOISE_PER_32;
        NOISE_RATE_64: noise_per = NOISE_PER_64;
        default: begin
          noise_per = (tone_per_r[NUM_TONES-1] == '0) ? PERIOD_W'(1)
                                                      : tone_per_r[NUM_TONES-1];
        end
      endcase

      // The shift register advances on every second noise reload.
      if (cnt_r[NUM_CHANS-1] <= PERIOD_W'(1)) begin
        cnt_nxt[NUM_CHANS-1] = noise_per;
        noise_tog_nxt        = ~noise_tog_r;
        if (!noise_tog_r) begin
          fb       = noise_ctl_r[2] ? (lfsr_r[0] ^ lfsr_r[3]) : lfsr_r[0];
          lfsr_nxt = {fb, lfsr_r[LFSR_W-1:1]};
        end
      end else begin
        cnt_nxt[NUM_CHANS-1] = cnt_r[NUM_CHANS-1] - PERIOD_W'(1);
      end
    end
  end

  // Levels seen after the request takes effect.
  always_comb begin
    chan_bits = {lfsr_nxt[0], tone_out_nxt};
    left_sum  = '0;
    right_sum = '0;
    for (int i = 0; i < NUM_CHANS; i++) begin
      amp[i] = chan_bits[i] ? vol_amp(atten_nxt[i]) : '0;
      if (mask_r[i + NUM_CHANS]) begin
        left_sum = left_sum + LEVEL_W'(amp[i]);
      end
      if (mask_r[i]) begin
        right_sum = right_sum + LEVEL_W'(amp[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r.left_level   <= left_sum;
      out_item_r.right_level  <= right_sum;
      out_item_r.channel_bits <= chan_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      lat_ch_r    <= '0;
      lat_vol_r   <= 1'b0;
      noise_ctl_r <= '0;
      tone_out_r  <= '1;
      noise_tog_r <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_per_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CHANS; i++) begin
        atten_r[i] <= ATTEN_MUTE;
        cnt_r[i]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
      if (adv) begin
        lat_ch_r    <= lat_ch_nxt;
        lat_vol_r   <= lat_vol_nxt;
        tone_per_r  <= tone_per_nxt;
        noise_ctl_r <= noise_ctl_nxt;
        atten_r     <= atten_nxt;
        cnt_r       <= cnt_nxt;
        tone_out_r  <= tone_out_nxt;
        noise_tog_r <= noise_tog_nxt;
        lfsr_r      <= lfsr_nxt;
      end
    end
  end

  `PSG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r,
    "pipeline not empty after reset")
  `PSG_ASSERT(a_lfsr_live, lfsr_r != '0, "noise shift register reached zero")
  `PSG_ASSERT(a_noise_seed, adv && noise_wr |=> lfsr_r == LFSR_SEED,
    "noise write did not reseed the shift register")
  `PSG_ASSERT(a_tone_park,
    adv && s1_item_r.action == ACT_TICK && tone_per_r[0] <= PERIOD_W'(1) |=> tone_out_r[0],
    "short-period tone not held high")
  `PSG_ASSERT(a_no_extra,
    out_valid_r && !out_stall && !s1_valid_r |=> !out_valid_r,
    "result shown without a request behind it")

endmodule

`default_nettype wire
